### rtl/core/vmt_pkg.sv
// shared types, constants and reset values for the vertex matrix transform unit
package vmt_pkg;

  // default word format, signed fixed point
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // stream field slots and matrix geometry
  localparam int FIELD_W    = 32;
  localparam int NUM_COMP   = 4;
  localparam int NUM_ROWS   = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 8;
  localparam int NUM_REGS   = 2 * NUM_ROWS;

  // low bit of a register index selects the half of a matrix row
  localparam logic HALF_COLS01 = 1'b0;
  localparam logic HALF_COLS23 = 1'b1;

  // identity entry 1.0 placed in the low or high entry of a register
  localparam logic [CFG_DATA_W-1:0] ONE_LO = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] ONE_HI = 64'h0001_0000_0000_0000;

  // write strobes and data for one matrix row
  typedef struct packed {
    logic                  we01;
    logic                  we23;
    logic [CFG_DATA_W-1:0] data;
  } vmt_cfg_wr_t;

  // reset contents of a row register: identity matrix
  function automatic logic [CFG_DATA_W-1:0] reset_cols01(input int row);
    logic [CFG_DATA_W-1:0] val;
    val = '0;
    if (row == 0) val = ONE_LO;
    if (row == 1) val = ONE_HI;
    return val;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reset_cols23(input int row);
    logic [CFG_DATA_W-1:0] val;
    val = '0;
    if (row == 2) val = ONE_LO;
    if (row == 3) val = ONE_HI;
    return val;
  endfunction

endpackage

### rtl/core/vmt_cell.sv
// one matrix row cell: holds its row, multiplies its vertex component, adds into the sums
module vmt_cell #(
  parameter int ROW         = 0,
  parameter int COORD_WIDTH = vmt_pkg::COORD_WIDTH_DEF,
  parameter int ACC_WIDTH   = 2 * vmt_pkg::COORD_WIDTH_DEF + 2
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  vmt_pkg::vmt_cfg_wr_t                          cfg_wr,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [vmt_pkg::NUM_COMP-1:0][COORD_WIDTH-1:0] in_vert,
  input  logic [vmt_pkg::NUM_COMP-1:0][ACC_WIDTH-1:0]   in_acc,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [vmt_pkg::NUM_COMP-1:0][COORD_WIDTH-1:0] out_vert,
  output logic [vmt_pkg::NUM_COMP-1:0][ACC_WIDTH-1:0]   out_acc
);
  import vmt_pkg::*;

  localparam int PROD_WIDTH = 2 * COORD_WIDTH;

  logic [CFG_DATA_W-1:0] cols01;
  logic [CFG_DATA_W-1:0] cols23;

  logic signed [COORD_WIDTH-1:0] coef [NUM_COMP];
  logic signed [COORD_WIDTH-1:0] comp;

  // product stage
  logic                                  a_valid;
  logic                                  a_ready;
  logic signed [PROD_WIDTH-1:0]          prod [NUM_COMP];
  logic [NUM_COMP-1:0][ACC_WIDTH-1:0]    a_acc;
  logic [NUM_COMP-1:0][COORD_WIDTH-1:0]  a_vert;

  // accumulate stage
  logic                                  b_valid;
  logic                                  b_ready;
  logic [NUM_COMP-1:0][ACC_WIDTH-1:0]    b_acc;
  logic [NUM_COMP-1:0][COORD_WIDTH-1:0]  b_vert;

  // row registers; the user must write them only while the unit is idle, the cell does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cols01 <= reset_cols01(ROW);
      cols23 <= reset_cols23(ROW);
    end else begin
      if (cfg_wr.we01) cols01 <= cfg_wr.data;
      if (cfg_wr.we23) cols23 <= cfg_wr.data;
    end
  end

  // row entries use the low word bits of each 32-bit slot
  assign coef[0] = cols01[COORD_WIDTH-1:0];
  assign coef[1] = cols01[FIELD_W +: COORD_WIDTH];
  assign coef[2] = cols23[COORD_WIDTH-1:0];
  assign coef[3] = cols23[FIELD_W +: COORD_WIDTH];
  assign comp    = in_vert[ROW];

  // stage handshake, a stage loads when empty or when its content moves on
  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
    end
  end

  // products of this row, one multiplier per column
  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        prod[j] <= PROD_WIDTH'(comp) * PROD_WIDTH'(coef[j]);
      end
      a_acc  <= in_acc;
      a_vert <= in_vert;
    end
  end

  // add the sign-extended products into the running sums
  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        b_acc[j] <= a_acc[j] + {{(ACC_WIDTH - PROD_WIDTH){prod[j][PROD_WIDTH-1]}}, prod[j]};
      end
      b_vert <= a_vert;
    end
  end

  assign out_valid = b_valid;
  assign out_acc   = b_acc;
  assign out_vert  = b_vert;

endmodule

### rtl/core/vmt_out.sv
// output cell: floor shift, saturation and the result register
module vmt_out #(
  parameter int COORD_WIDTH = vmt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = vmt_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH   = 2 * vmt_pkg::COORD_WIDTH_DEF + 2
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [vmt_pkg::NUM_COMP-1:0][ACC_WIDTH-1:0]    in_acc,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [vmt_pkg::NUM_COMP-1:0][vmt_pkg::FIELD_W-1:0] out_comp,
  output logic                                           out_sat
);
  import vmt_pkg::*;

  // the kept word's sign bit and all bits above it, which must all be equal
  localparam int TOP_LO = FRAC_BITS + COORD_WIDTH - 1;

  localparam logic [COORD_WIDTH-1:0] MAX_VAL = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MIN_VAL = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic [NUM_COMP-1:0][COORD_WIDTH-1:0] clamped;
  logic [NUM_COMP-1:0]                  ovf;
  logic [ACC_WIDTH-TOP_LO-1:0]          top_bits [NUM_COMP];

  // shift right by the fraction bits is a bit-select, floor for two's complement
  always_comb begin
    for (int j = 0; j < NUM_COMP; j++) begin
      top_bits[j] = in_acc[j][ACC_WIDTH-1:TOP_LO];
      ovf[j]      = !((&top_bits[j]) || !(|top_bits[j]));
      if (ovf[j]) begin
        clamped[j] = in_acc[j][ACC_WIDTH-1] ? MIN_VAL : MAX_VAL;
      end else begin
        clamped[j] = in_acc[j][TOP_LO:FRAC_BITS];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // result register, components sign-extended into their 32-bit slots
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        out_comp[j] <= FIELD_W'(signed'(clamped[j]));
      end
      out_sat <= |ovf;
    end
  end

endmodule

### rtl/core/vertex_matrix_transform_unit.sv
// top level of the vertex matrix transform unit: config decode and the chain of row cells
//
// Multiplies each vertex (x, y, z, w), taken as a row vector, by a 4x4 signed
// fixed-point matrix and returns the floor-shifted, saturated result with a flag
// that reports any clamped component. One vertex is accepted every clock unless a
// stalled result has backed up the stages; each vertex passes four row cells of two
// register stages each (multiply, then add into the running column sums) and the
// output register. Every stage moves on independently, so bubbles close up and input
// keeps flowing while a finished result waits to be taken, until every stage is full.
// Matrix registers are written through the config channel, which is always
// ready; write them only while no vertex is in flight. Reset loads the identity.
module vertex_matrix_transform_unit #(
  parameter int COORD_WIDTH = vmt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = vmt_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // config write channel
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [vmt_pkg::CFG_IDX_W-1:0]                 cfg_index,
  input  logic [vmt_pkg::CFG_DATA_W-1:0]                cfg_data,
  // vertex in
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // tdata from bit 0: in_x[31:0], in_y[63:32], in_z[95:64], in_w[127:96]
  input  logic [vmt_pkg::NUM_COMP*vmt_pkg::FIELD_W-1:0] s_axis_tdata,
  // vertex out
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // tdata from bit 0: out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [vmt_pkg::NUM_COMP*vmt_pkg::FIELD_W-1:0] m_axis_tdata,
  // tuser: saturated[0]
  output logic [0:0]                                    m_axis_tuser
);
  import vmt_pkg::*;

  localparam int ACC_WIDTH = 2 * COORD_WIDTH + 2;
  localparam int ROW_W     = $clog2(NUM_ROWS);

  vmt_cfg_wr_t cfg_wr [NUM_ROWS];

  logic                                 link_valid [NUM_ROWS+1];
  logic                                 link_ready [NUM_ROWS+1];
  logic [NUM_COMP-1:0][COORD_WIDTH-1:0] link_vert  [NUM_ROWS+1];
  logic [NUM_COMP-1:0][ACC_WIDTH-1:0]   link_acc   [NUM_ROWS+1];

  logic [NUM_COMP-1:0][FIELD_W-1:0]     out_comp;
  logic                                 in_range;

  assign cfg_ready = 1'b1;
  assign in_range  = (cfg_index < CFG_IDX_W'(NUM_REGS));

  // config decode: index bits above the half select pick the row
  always_comb begin
    for (int k = 0; k < NUM_ROWS; k++) begin
      cfg_wr[k].data = cfg_data;
      cfg_wr[k].we01 = cfg_valid && in_range && (cfg_index[ROW_W:1] == ROW_W'(k))
                       && (cfg_index[0] == HALF_COLS01);
      cfg_wr[k].we23 = cfg_valid && in_range && (cfg_index[ROW_W:1] == ROW_W'(k))
                       && (cfg_index[0] == HALF_COLS23);
    end
  end

  // head of the chain: unpack the vertex, sums start at zero
  assign link_valid[0] = s_axis_tvalid;
  assign s_axis_tready = link_ready[0];
  assign link_acc[0]   = '0;
  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      link_vert[0][i] = s_axis_tdata[i*FIELD_W +: COORD_WIDTH];
    end
  end

  // one cell per matrix row
  for (genvar k = 0; k < NUM_ROWS; k++) begin : g_cell
    vmt_cell #(
      .ROW         (k),
      .COORD_WIDTH (COORD_WIDTH),
      .ACC_WIDTH   (ACC_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg_wr    (cfg_wr[k]),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_vert   (link_vert[k]),
      .in_acc    (link_acc[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_vert  (link_vert[k+1]),
      .out_acc   (link_acc[k+1])
    );
  end

  // shift, clamp and hold the result
  vmt_out #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (link_valid[NUM_ROWS]),
    .in_ready  (link_ready[NUM_ROWS]),
    .in_acc    (link_acc[NUM_ROWS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_comp  (out_comp),
    .out_sat   (m_axis_tuser[0])
  );

  assign m_axis_tdata = out_comp;

endmodule

### rtl/core/vmt_checker.sv
// port-level checks for the vertex matrix transform unit, bound to the top level
module vmt_checker #(
  parameter int COORD_WIDTH = vmt_pkg::COORD_WIDTH_DEF
) (
  input logic                                          clk,
  input logic                                          rst,
  input logic                                          cfg_ready,
  input logic                                          s_axis_tvalid,
  input logic                                          s_axis_tready,
  input logic                                          m_axis_tvalid,
  input logic                                          m_axis_tready,
  input logic [vmt_pkg::NUM_COMP*vmt_pkg::FIELD_W-1:0] m_axis_tdata,
  input logic [0:0]                                    m_axis_tuser
);
  import vmt_pkg::*;

  // clamp limits as they show in a 32-bit slot
  localparam logic [FIELD_W-1:0] MAX_VAL =
    FIELD_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic [FIELD_W-1:0] MIN_VAL = ~MAX_VAL;
  localparam int MAX_INFLIGHT = 2 * NUM_ROWS + 1;

  logic       in_req;
  logic       out_req;
  logic [4:0] inflight;

  assign in_req  = s_axis_tvalid && s_axis_tready;
  assign out_req = m_axis_tvalid && m_axis_tready;

  // vertices accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 5'(in_req) - 5'(out_req);
    end
  end

  // the config channel never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config channel stalled");

  // a result is shown only for a vertex that went in
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (inflight != 5'd0))
    else $error("result without a pending vertex");

  // the pipeline never holds more vertices than it has stages
  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 5'(MAX_INFLIGHT))
    else $error("more vertices in flight than stages");

  // a saturation flag comes with at least one component at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[31:0]   == MAX_VAL || m_axis_tdata[31:0]   == MIN_VAL ||
       m_axis_tdata[63:32]  == MAX_VAL || m_axis_tdata[63:32]  == MIN_VAL ||
       m_axis_tdata[95:64]  == MAX_VAL || m_axis_tdata[95:64]  == MIN_VAL ||
       m_axis_tdata[127:96] == MAX_VAL || m_axis_tdata[127:96] == MIN_VAL))
    else $error("saturation flagged with no clamped component");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind vertex_matrix_transform_unit vmt_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_vmt_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_ready     (cfg_ready),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### verif/vertex_transform_checker.sv
// checker for the vertex matrix transform unit: mirrors the matrix, predicts and compares results
module vertex_transform_checker (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_valid,
  input  logic                                          cfg_ready,
  input  logic [vmt_pkg::CFG_IDX_W-1:0]                 cfg_index,
  input  logic [vmt_pkg::CFG_DATA_W-1:0]                cfg_data,
  input  logic                                          in_valid,
  input  logic                                          in_ready,
  // from bit 0: in_x, in_y, in_z, in_w
  input  logic [vmt_pkg::NUM_COMP*vmt_pkg::FIELD_W-1:0] in_data,
  input  logic                                          out_valid,
  input  logic                                          out_ready,
  // from bit 0: out_x, out_y, out_z, out_w
  input  logic [vmt_pkg::NUM_COMP*vmt_pkg::FIELD_W-1:0] out_data,
  // saturated
  input  logic [0:0]                                    out_flag,
  output int unsigned                                   pending,
  output int unsigned                                   mismatches
);
  import vmt_pkg::*;

  localparam int ACC_W = 2 * FIELD_W + 4;
  localparam logic signed [ACC_W-1:0] COORD_HI = (ACC_W'(1) <<< (COORD_WIDTH_DEF - 1)) - 1;
  localparam logic signed [ACC_W-1:0] COORD_LO = -(ACC_W'(1) <<< (COORD_WIDTH_DEF - 1));
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  typedef struct packed {
    logic                              sat;
    logic [NUM_COMP-1:0][FIELD_W-1:0]  comp;
  } vertex_result_t;

  logic [CFG_DATA_W-1:0] matrix_regs [NUM_REGS];
  vertex_result_t        expected_q [$];
  int unsigned           error_count;

  initial begin
    pending     = 0;
    mismatches  = 0;
    error_count = 0;
  end

  // one matrix entry m[row][col]: low or high half of the row register
  function automatic logic [FIELD_W-1:0] matrix_entry(input int row, input int col);
    logic [CFG_DATA_W-1:0] word;
    word = matrix_regs[{row[1:0], col[1]}];
    return col[0] ? word[2*FIELD_W-1:FIELD_W] : word[FIELD_W-1:0];
  endfunction

  // row vector times matrix, exact sum, floor shift, clamp
  function automatic vertex_result_t transform_vertex(
      input logic [NUM_COMP*FIELD_W-1:0] vtx);
    vertex_result_t          res;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] floored;
    logic signed [63:0]      a;
    logic signed [63:0]      b;
    int                      row;
    int                      col;
    res = '0;
    for (col = 0; col < NUM_COMP; col++) begin
      acc = '0;
      for (row = 0; row < NUM_ROWS; row++) begin
        a = signed'(vtx[row*FIELD_W +: FIELD_W]);
        b = signed'(matrix_entry(row, col));
        acc = acc + a * b;
      end
      floored = acc >>> FRAC_BITS_DEF;
      if (floored > COORD_HI) begin
        floored = COORD_HI;
        res.sat = 1'b1;
      end else if (floored < COORD_LO) begin
        floored = COORD_LO;
        res.sat = 1'b1;
      end
      res.comp[col] = floored[FIELD_W-1:0];
    end
    return res;
  endfunction

  // watch all three channels on the rising edge
  always @(posedge clk) begin : watch
    vertex_result_t want;
    vertex_result_t got;
    logic           bad;
    int             k;
    if (rst) begin
      for (k = 0; k < NUM_REGS; k++) begin
        matrix_regs[k] = '0;
      end
      // identity matrix
      matrix_regs[{2'd0, HALF_COLS01}] = ONE_LO;
      matrix_regs[{2'd1, HALF_COLS01}] = ONE_HI;
      matrix_regs[{2'd2, HALF_COLS23}] = ONE_LO;
      matrix_regs[{2'd3, HALF_COLS23}] = ONE_HI;
      expected_q.delete();
    end else begin
      // register writes, out of range indexes do nothing
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) begin
        matrix_regs[cfg_index[REG_IDX_W-1:0]] = cfg_data;
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(transform_vertex(in_data));
      end
      // compare each result with the oldest expectation
      if (out_valid && out_ready) begin
        got.comp = out_data;
        got.sat  = out_flag[0];
        if (expected_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected result: x %h y %h z %h w %h sat %b",
                     got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.sat);
          end
        end else begin
          want = expected_q.pop_front();
          bad  = (want.sat != got.sat);
          for (k = 0; k < NUM_COMP; k++) begin
            if (want.comp[k] != got.comp[k]) bad = 1'b1;
          end
          if (bad) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch: expected x %h y %h z %h w %h sat %b",
                       want.comp[0], want.comp[1], want.comp[2], want.comp[3], want.sat);
              $display("          got      x %h y %h z %h w %h sat %b",
                       got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.sat);
            end
          end
        end
      end
    end
    pending    <= expected_q.size();
    mismatches <= error_count;
  end

endmodule

### verif/vertex_matrix_transform_unit_test.sv
// testbench top for the vertex matrix transform unit: clock, reset, stimulus and verdict
module vertex_matrix_transform_unit_test;
  import vmt_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 210;

  localparam logic [FIELD_W-1:0] COORD_MAX = 32'h7fff_ffff;
  localparam logic [FIELD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] FX_ONE    = 32'h0001_0000;
  localparam logic [FIELD_W-1:0] FX_HALF   = 32'h0000_8000;

  typedef enum int {
    MAT_IDENTITY, MAT_HALF, MAT_SMALL, MAT_FULL, MAT_ALL_MAX, MAT_ALL_MIN, MAT_MIXED
  } matrix_kind_e;

  typedef enum int {COORD_SMALL, COORD_FULL, COORD_EDGE} coord_kind_e;

  logic                              clk;
  logic                              rst;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [CFG_IDX_W-1:0]              cfg_index;
  logic [CFG_DATA_W-1:0]             cfg_data;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [NUM_COMP*FIELD_W-1:0]       s_axis_tdata;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [NUM_COMP*FIELD_W-1:0]       m_axis_tdata;
  logic [0:0]                        m_axis_tuser;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned cycle_count;
  logic        calm;

  vertex_matrix_transform_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  vertex_transform_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_flag   (m_axis_tuser),
    .pending    (pending),
    .mismatches (mismatches)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  initial begin : result_stall
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        m_axis_tready = 1'b1;
      end else if (hold == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          m_axis_tready = 1'b0;
          hold = $urandom_range(1, 8) - 1;
        end else begin
          m_axis_tready = 1'b1;
          hold = $urandom_range(1, 16) - 1;
        end
      end else begin
        hold--;
      end
    end
  end

  function automatic logic [FIELD_W-1:0] pick_coord(input coord_kind_e kind);
    logic [FIELD_W-1:0] v;
    case (kind)
      // about +-256.0
      COORD_SMALL: v = $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
      COORD_FULL:  v = $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0:       v = COORD_MAX;
          1:       v = COORD_MIN;
          2:       v = '0;
          3:       v = '1;
          4:       v = FX_ONE;
          default: v = -FX_ONE;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [NUM_COMP*FIELD_W-1:0] random_vertex();
    logic [NUM_COMP*FIELD_W-1:0] vtx;
    int                          k;
    int                          roll;
    for (k = 0; k < NUM_COMP; k++) begin
      roll = $urandom_range(0, 9);
      if (roll < 6) vtx[k*FIELD_W +: FIELD_W] = pick_coord(COORD_SMALL);
      else if (roll < 9) vtx[k*FIELD_W +: FIELD_W] = pick_coord(COORD_FULL);
      else vtx[k*FIELD_W +: FIELD_W] = pick_coord(COORD_EDGE);
    end
    return vtx;
  endfunction

  // one vertex request, with an occasional idle burst ahead of it
  task automatic send_vertex(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                             input logic [FIELD_W-1:0] z, input logic [FIELD_W-1:0] w);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {w, z, y, x};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random_vertex();
    logic [NUM_COMP*FIELD_W-1:0] vtx;
    vtx = random_vertex();
    send_vertex(vtx[0 +: FIELD_W], vtx[FIELD_W +: FIELD_W],
                vtx[2*FIELD_W +: FIELD_W], vtx[3*FIELD_W +: FIELD_W]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop sending, then hold off until every expected result is back
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // fill all eight row registers, then one write to a nonexistent index
  task automatic load_matrix(input matrix_kind_e kind);
    logic [FIELD_W-1:0] m [NUM_ROWS][NUM_COMP];
    logic [1:0]         r2;
    int                 r;
    int                 c;
    for (r = 0; r < NUM_ROWS; r++) begin
      for (c = 0; c < NUM_COMP; c++) begin
        case (kind)
          MAT_IDENTITY: m[r][c] = (r == c) ? FX_ONE : '0;
          MAT_HALF:     m[r][c] = FX_HALF;
          // about +-4.0
          MAT_SMALL:    m[r][c] = $urandom_range(0, 32'h0007_ffff) - 32'h0004_0000;
          MAT_FULL:     m[r][c] = $urandom;
          MAT_ALL_MAX:  m[r][c] = COORD_MAX;
          MAT_ALL_MIN:  m[r][c] = COORD_MIN;
          default: begin
            case ($urandom_range(0, 2))
              0:       m[r][c] = $urandom_range(0, 32'h0007_ffff) - 32'h0004_0000;
              1:       m[r][c] = $urandom;
              default: m[r][c] = pick_coord(COORD_EDGE);
            endcase
          end
        endcase
      end
    end
    for (r = 0; r < NUM_ROWS; r++) begin
      r2 = r[1:0];
      write_reg(CFG_IDX_W'({r2, HALF_COLS01}), {m[r][1], m[r][0]});
      write_reg(CFG_IDX_W'({r2, HALF_COLS23}), {m[r][3], m[r][2]});
    end
    write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
              {$urandom, $urandom});
  endtask

  // stimulus and verdict
  initial begin : stimulus
    matrix_kind_e plan [8];
    int           phase;
    int           n;
    int           pause_at;
    plan = '{MAT_SMALL, MAT_FULL, MAT_MIXED, MAT_IDENTITY,
             MAT_ALL_MAX, MAT_SMALL, MAT_ALL_MIN, MAT_MIXED};
    calm          = 1'b0;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity after reset: extremes pass through unchanged
    send_vertex('0, '0, '0, '0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(FX_ONE, -FX_ONE, '1, FX_ONE);
    wait_drained();

    // half entries: shift rounds toward minus infinity
    load_matrix(MAT_HALF);
    send_vertex(32'h1, '0, '0, '0);
    send_vertex('1, '0, '0, '0);
    send_vertex('1, '1, '1, '0);
    send_vertex(FX_ONE, FX_ONE, FX_ONE, FX_ONE);
    wait_drained();

    // all largest entries: clamp high and low
    load_matrix(MAT_ALL_MAX);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(FX_ONE, '0, '0, '0);
    send_vertex(COORD_MAX, COORD_MIN, '0, '0);
    wait_drained();

    // all smallest entries: min times min overflows upward
    load_matrix(MAT_ALL_MIN);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_vertex('1, '0, '0, '0);
    send_vertex(COORD_MIN, '0, '0, '0);
    wait_drained();

    // random phases, each with its own matrix; last one without idle bursts or stalls
    for (phase = 0; phase < 8; phase++) begin
      load_matrix(plan[phase]);
      if (phase == 7) calm = 1'b1;
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == pause_at) begin
          wait_drained();
        end
        send_random_vertex();
      end
      wait_drained();
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/vmt_pkg.sv
rtl/core/vmt_cell.sv
rtl/core/vmt_out.sv
rtl/core/vertex_matrix_transform_unit.sv
rtl/core/vmt_checker.sv
verif/vertex_transform_checker.sv
verif/vertex_matrix_transform_unit_test.sv
